[hdl/vpp_pkg.sv]
// Shared types, widths, register codes and reset values for the vertex projection block.
// Used by every module of the block; depends on nothing.

package vpp_pkg;

    localparam int VTX_W     = 16;  // Q8.8 input coordinate
    localparam int COEF_W    = 16;  // Q4.12 matrix coefficient
    localparam int ROW_W     = 64;  // four coefficients per matrix row
    localparam int SIZE_W    = 13;  // screen size register
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 32;  // Q8.8 times Q4.12
    localparam int SUM_W     = 32;  // clamped Q12.20 sum
    localparam int FSUM_W    = 34;  // exact sum of three products and the offset
    localparam int NUM_W     = 40;  // dividend magnitude, sum times 256
    localparam int DEN_W     = 32;  // divisor magnitude
    localparam int ZNDC_W    = 20;  // undivided sum in Q12.8
    localparam int NDC_W     = 41;  // signed quotient at full width
    localparam int T_W       = 27;  // ndc + 1, clamped so that saturation is kept
    localparam int SPROD_W   = 41;  // clamped ndc times screen size
    localparam int OUT_W     = 16;
    localparam int LANES     = 3;   // x, y and z are divided by the same w
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 3'd5;

    localparam logic [ROW_W-1:0]  ROW_X_RESET   = 64'h0000_0000_0000_0F00;
    localparam logic [ROW_W-1:0]  ROW_Y_RESET   = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0]  ROW_Z_RESET   = 64'h1000_1000_0000_0000;
    localparam logic [ROW_W-1:0]  ROW_OFS_RESET = 64'h0000_FE66_0000_0000;
    localparam logic [SIZE_W-1:0] SCR_W_RESET   = 13'd256;
    localparam logic [SIZE_W-1:0] SCR_H_RESET   = 13'd240;

    // One transformed vertex as it waits between the front and the back.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic signed [SUM_W-1:0] sum_w;
        logic                    sat;
    } xform_t;

    function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                      input int k);
        return row[COEF_W*k +: COEF_W];
    endfunction

endpackage

[hdl/vertex_perspective_projection.sv]
// Top level of the vertex perspective projection block: configuration registers and the
// front, queue and back parts. Depends on vpp_pkg, vpp_front, vpp_queue and vpp_back.

// The block takes one vertex (x, y, z in signed Q8.8) per clock cycle while s_tready is
// high and returns one projected result per vertex, in order. Each vertex is multiplied as
// (x, y, z, 1) by a 4x4 matrix of Q4.12 coefficients, x, y and z are divided by w, and x
// and y are scaled to the viewport. Throughput is one transaction per cycle when neither
// side stalls; the longest part of the pipeline is the 40-stage divider that produces one
// quotient bit per stage. Two multiply and sum stages feed a small queue, so input
// transactions are still taken for a while after the output side stalls. When w is zero
// the undivided values are passed on and w_was_zero is set; saturated is set when any sum
// or output was clamped. Configuration writes must only happen while the block is empty.
// After reset the matrix and viewport hold the default projection.

module vertex_perspective_projection
#(
    parameter int QueueDepth = vpp_pkg::QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpp_pkg::ROW_W-1:0]          cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,   // vert_x, vert_y, vert_z
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,   // screen_x, screen_y, depth
    output logic [1:0]                         m_tuser    // w_was_zero, saturated
);

    localparam int VW = vpp_pkg::VTX_W;
    localparam int OW = vpp_pkg::OUT_W;

    logic [vpp_pkg::ROW_W-1:0]  row_x_reg, row_y_reg, row_z_reg, row_ofs_reg;
    logic [vpp_pkg::SIZE_W-1:0] scr_w_reg, scr_h_reg;

    logic                       f_valid;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    vpp_pkg::xform_t            f_data;
    vpp_pkg::xform_t            q_data;
    logic signed [OW-1:0]       sx, sy, dz;
    logic                       wz, sat;

    // Configuration writes land directly; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg   <= vpp_pkg::ROW_X_RESET;
            row_y_reg   <= vpp_pkg::ROW_Y_RESET;
            row_z_reg   <= vpp_pkg::ROW_Z_RESET;
            row_ofs_reg <= vpp_pkg::ROW_OFS_RESET;
            scr_w_reg   <= vpp_pkg::SCR_W_RESET;
            scr_h_reg   <= vpp_pkg::SCR_H_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vpp_pkg::REG_ROW_X:   row_x_reg   <= cfg_data;
                vpp_pkg::REG_ROW_Y:   row_y_reg   <= cfg_data;
                vpp_pkg::REG_ROW_Z:   row_z_reg   <= cfg_data;
                vpp_pkg::REG_ROW_OFS: row_ofs_reg <= cfg_data;
                vpp_pkg::REG_SCR_W:   scr_w_reg   <= cfg_data[vpp_pkg::SIZE_W-1:0];
                vpp_pkg::REG_SCR_H:   scr_h_reg   <= cfg_data[vpp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // The front runs the matrix multiply; it holds only while its last stage
    // cannot move into a full queue.
    vpp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_x     (row_x_reg),
        .row_y     (row_y_reg),
        .row_z     (row_z_reg),
        .row_ofs   (row_ofs_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vert_x    (s_tdata[VW-1:0]),
        .vert_y    (s_tdata[2*VW-1:VW]),
        .vert_z    (s_tdata[3*VW-1:2*VW]),
        .out_valid (f_valid),
        .out_ready (!q_full),
        .out_data  (f_data)
    );

    vpp_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (f_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // The back advances as a whole whenever the output register is free or taken.
    vpp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (scr_w_reg),
        .screen_height (scr_h_reg),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .screen_x      (sx),
        .screen_y      (sy),
        .depth         (dz),
        .w_was_zero    (wz),
        .saturated     (sat)
    );

    assign m_tdata = {dz, sy, sx};
    assign m_tuser = {sat, wz};

endmodule

[hdl/vpp_front.sv]
// Front of the vertex projection block: matrix multiply and clamp of the four sums.
// Depends on vpp_pkg.

module vpp_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vpp_pkg::ROW_W-1:0]          row_x,
    input  logic [vpp_pkg::ROW_W-1:0]          row_y,
    input  logic [vpp_pkg::ROW_W-1:0]          row_z,
    input  logic [vpp_pkg::ROW_W-1:0]          row_ofs,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [vpp_pkg::VTX_W-1:0]   vert_x,
    input  logic signed [vpp_pkg::VTX_W-1:0]   vert_y,
    input  logic signed [vpp_pkg::VTX_W-1:0]   vert_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output vpp_pkg::xform_t                    out_data
);

    localparam int PW = vpp_pkg::PROD_W;
    localparam int FW = vpp_pkg::FSUM_W;
    localparam int SW = vpp_pkg::SUM_W;
    localparam logic signed [FW-1:0] FS_MAX = {{(FW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [FW-1:0] FS_MIN = {{(FW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic                   en;
    logic                   a_valid_reg;
    logic                   b_valid_reg;
    logic signed [PW-1:0]   px_reg [4];
    logic signed [PW-1:0]   py_reg [4];
    logic signed [PW-1:0]   pz_reg [4];
    logic signed [SW-1:0]   sum_next [4];
    logic [3:0]             clip_next;
    vpp_pkg::xform_t        b_data_reg;

    assign en        = !b_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                px_reg[k] <= PW'(vert_x) * PW'(vpp_pkg::coef(row_x, k));
                py_reg[k] <= PW'(vert_y) * PW'(vpp_pkg::coef(row_y, k));
                pz_reg[k] <= PW'(vert_z) * PW'(vpp_pkg::coef(row_z, k));
            end
        end
    end

    // Exact sum of the three products and the offset, clamped to the Q12.20 range.
    always_comb
    begin
        logic signed [FW-1:0] fs;
        for (int k = 0; k < 4; k++)
        begin
            fs = FW'(px_reg[k]) + FW'(py_reg[k]) + FW'(pz_reg[k])
               + (FW'(vpp_pkg::coef(row_ofs, k)) <<< 8);
            clip_next[k] = 1'b1;
            if (fs > FS_MAX)
                sum_next[k] = FS_MAX[SW-1:0];
            else if (fs < FS_MIN)
                sum_next[k] = FS_MIN[SW-1:0];
            else
            begin
                sum_next[k]  = fs[SW-1:0];
                clip_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg.sum_x <= sum_next[0];
            b_data_reg.sum_y <= sum_next[1];
            b_data_reg.sum_z <= sum_next[2];
            b_data_reg.sum_w <= sum_next[3];
            b_data_reg.sat   <= |clip_next;
        end
    end

endmodule

[hdl/vpp_queue.sv]
// Short first-in first-out queue of transformed vertices between front and back.
// Depends on vpp_pkg.

module vpp_queue
#(
    parameter int Depth = vpp_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vpp_pkg::xform_t push_data,
    output logic            full,
    input  logic            pop,
    output vpp_pkg::xform_t pop_data,
    output logic            empty
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    vpp_pkg::xform_t    mem_reg [Depth];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(Depth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hdl/vpp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three dividends over one divisor.
// Depends on vpp_pkg.

module vpp_div
(
    input  logic                                                 clk,
    input  logic                                                 en,
    input  logic [vpp_pkg::LANES-1:0][vpp_pkg::NUM_W-1:0]        num,
    input  logic [vpp_pkg::DEN_W-1:0]                            den,
    output logic [vpp_pkg::LANES-1:0][vpp_pkg::NUM_W-1:0]        quo
);

    localparam int NW = vpp_pkg::NUM_W;
    localparam int DW = vpp_pkg::DEN_W;
    localparam int LN = vpp_pkg::LANES;

    // Outputs of each stage; the low bits of nq fill with quotient bits.
    logic [LN-1:0][DW-1:0] rem_q [NW];
    logic [LN-1:0][NW-1:0] nq_q  [NW];
    logic [DW-1:0]         den_q [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [LN-1:0][DW-1:0] rem_in;
        logic [LN-1:0][NW-1:0] nq_in;
        logic [DW-1:0]         den_in;
        logic [LN-1:0][DW-1:0] rem_next;
        logic [LN-1:0][NW-1:0] nq_next;
        logic [LN-1:0][DW-1:0] rem_reg;
        logic [LN-1:0][NW-1:0] nq_reg;
        logic [DW-1:0]         den_reg;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_q[i-1];
            assign nq_in  = nq_q[i-1];
            assign den_in = den_q[i-1];
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            for (int l = 0; l < LN; l++)
            begin
                trial = {rem_in[l], nq_in[l][NW-1]};
                diff  = trial - {1'b0, den_in};
                if (!diff[DW])
                begin
                    rem_next[l] = diff[DW-1:0];
                    nq_next[l]  = {nq_in[l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[DW-1:0];
                    nq_next[l]  = {nq_in[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                nq_reg  <= nq_next;
                den_reg <= den_in;
            end
        end

        assign rem_q[i] = rem_reg;
        assign nq_q[i]  = nq_reg;
        assign den_q[i] = den_reg;
    end

    assign quo = nq_q[NW-1];

endmodule

[hdl/vpp_back.sv]
// Back of the vertex projection block: divide by w, screen scaling, clamps, output register.
// Depends on vpp_pkg and vpp_div.

module vpp_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vpp_pkg::SIZE_W-1:0]         screen_width,
    input  logic [vpp_pkg::SIZE_W-1:0]         screen_height,
    input  logic                               q_empty,
    output logic                               q_pop,
    input  vpp_pkg::xform_t                    q_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [vpp_pkg::OUT_W-1:0]   screen_x,
    output logic signed [vpp_pkg::OUT_W-1:0]   screen_y,
    output logic signed [vpp_pkg::OUT_W-1:0]   depth,
    output logic                               w_was_zero,
    output logic                               saturated
);

    localparam int NW = vpp_pkg::NUM_W;
    localparam int DW = vpp_pkg::DEN_W;
    localparam int SW = vpp_pkg::SUM_W;
    localparam int LN = vpp_pkg::LANES;
    localparam int ZW = vpp_pkg::ZNDC_W;
    localparam int QW = vpp_pkg::NDC_W;
    localparam int TW = vpp_pkg::T_W;
    localparam int MW = vpp_pkg::SPROD_W;
    localparam int OW = vpp_pkg::OUT_W;
    localparam int DSW = MW - 9;
    localparam logic signed [QW-1:0]  T_HI = QW'(64'sd1 <<< (TW - 2));
    localparam logic signed [QW-1:0]  T_LO = -T_HI;
    localparam logic signed [QW-1:0]  D_HI = QW'((64'sd1 <<< (OW - 1)) - 1);
    localparam logic signed [QW-1:0]  D_LO = -QW'(64'sd1 <<< (OW - 1));
    localparam logic signed [DSW-1:0] O_HI = DSW'((64'sd1 <<< (OW - 1)) - 1);
    localparam logic signed [DSW-1:0] O_LO = -DSW'(64'sd1 <<< (OW - 1));

    typedef struct packed {
        logic                            wz;
        logic                            sat;
        logic [LN-1:0]                   neg;
        logic [LN-1:0][ZW-1:0]           zndc;
    } side_t;

    logic                    en;
    logic                    s0_valid_reg;
    logic [LN-1:0][NW-1:0]   s0_num_reg;
    logic [DW-1:0]           s0_den_reg;
    side_t                   s0_sb_reg;
    side_t                   s0_sb_next;
    logic [LN-1:0][NW-1:0]   s0_num_next;
    logic [DW-1:0]           s0_den_next;
    logic [NW-1:0]           dv_reg;
    side_t                   sb_reg [NW];
    logic [LN-1:0][NW-1:0]   quo;

    logic                    p1_valid_reg, p2_valid_reg, p3_valid_reg, o_valid_reg;
    logic signed [QW-1:0]    ndc_reg [LN];
    logic                    p1_wz_reg, p1_sat_reg;
    logic signed [TW-1:0]    tx_reg, ty_reg;
    logic signed [OW-1:0]    dz_reg, p3_dz_reg;
    logic                    p2_wz_reg, p2_sat_reg, p3_wz_reg, p3_sat_reg;
    logic signed [MW-1:0]    mx_reg, my_reg;
    logic signed [OW-1:0]    sx_reg, sy_reg, o_dz_reg;
    logic                    o_wz_reg, o_sat_reg;

    assign en    = !o_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    // Magnitudes and signs for the divider, plus the undivided Q12.8 value.
    always_comb
    begin
        logic signed [SW-1:0] s [LN];
        logic signed [SW-1:0] r;
        logic [SW-1:0]        mag;
        s[0] = q_data.sum_x;
        s[1] = q_data.sum_y;
        s[2] = q_data.sum_z;
        s0_sb_next.wz  = (q_data.sum_w == '0);
        s0_sb_next.sat = q_data.sat;
        s0_den_next    = q_data.sum_w[SW-1] ? DW'(-q_data.sum_w) : DW'(q_data.sum_w);
        for (int l = 0; l < LN; l++)
        begin
            mag = s[l][SW-1] ? SW'(-s[l]) : SW'(s[l]);
            s0_num_next[l]       = {mag, 8'b0};
            s0_sb_next.neg[l]    = s[l][SW-1] ^ q_data.sum_w[SW-1];
            r                    = s[l] + (s[l][SW-1] ? SW'(4095) : SW'(0));
            s0_sb_next.zndc[l]   = r[SW-1 -: ZW];
        end
    end

    vpp_div u_div
    (
        .clk (clk),
        .en  (en),
        .num (s0_num_reg),
        .den (s0_den_reg),
        .quo (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            dv_reg       <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= !q_empty;
            dv_reg       <= {dv_reg[NW-2:0], s0_valid_reg};
            p1_valid_reg <= dv_reg[NW-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            o_valid_reg  <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [QW-1:0] q;
        logic signed [QW-1:0] t;
        logic signed [MW-1:0] rnd;
        logic signed [DSW-1:0] v;
        if (en)
        begin
            s0_num_reg <= s0_num_next;
            s0_den_reg <= s0_den_next;
            s0_sb_reg  <= s0_sb_next;
            sb_reg[0]  <= s0_sb_reg;
            for (int i = 1; i < NW; i++)
                sb_reg[i] <= sb_reg[i-1];

            // Sign the quotient, or take the undivided value when w is zero.
            for (int l = 0; l < LN; l++)
            begin
                q = $signed({1'b0, quo[l]});
                if (sb_reg[NW-1].wz)
                    ndc_reg[l] <= QW'($signed(sb_reg[NW-1].zndc[l]));
                else
                    ndc_reg[l] <= sb_reg[NW-1].neg[l] ? -q : q;
            end
            p1_wz_reg  <= sb_reg[NW-1].wz;
            p1_sat_reg <= sb_reg[NW-1].sat;

            // ndc + 1 is clamped to a range beyond which every nonzero screen size saturates.
            t = ndc_reg[0] + QW'(256);
            tx_reg <= (t > T_HI) ? T_HI[TW-1:0] : (t < T_LO) ? T_LO[TW-1:0] : t[TW-1:0];
            t = ndc_reg[1] + QW'(256);
            ty_reg <= (t > T_HI) ? T_HI[TW-1:0] : (t < T_LO) ? T_LO[TW-1:0] : t[TW-1:0];
            dz_reg <= (ndc_reg[2] > D_HI) ? D_HI[OW-1:0] :
                      (ndc_reg[2] < D_LO) ? D_LO[OW-1:0] : ndc_reg[2][OW-1:0];
            p2_sat_reg <= p1_sat_reg || (ndc_reg[2] > D_HI) || (ndc_reg[2] < D_LO);
            p2_wz_reg  <= p1_wz_reg;

            mx_reg     <= MW'(tx_reg) * MW'($signed({1'b0, screen_width}));
            my_reg     <= MW'(ty_reg) * MW'($signed({1'b0, screen_height}));
            p3_dz_reg  <= dz_reg;
            p3_wz_reg  <= p2_wz_reg;
            p3_sat_reg <= p2_sat_reg;

            // Divide by 512 truncating toward zero, then clamp to 16 bits.
            o_sat_reg <= p3_sat_reg;
            rnd = mx_reg + (mx_reg[MW-1] ? MW'(511) : MW'(0));
            v   = rnd[MW-1:9];
            sx_reg <= (v > O_HI) ? O_HI[OW-1:0] : (v < O_LO) ? O_LO[OW-1:0] : v[OW-1:0];
            if ((v > O_HI) || (v < O_LO))
                o_sat_reg <= 1'b1;
            rnd = my_reg + (my_reg[MW-1] ? MW'(511) : MW'(0));
            v   = rnd[MW-1:9];
            sy_reg <= (v > O_HI) ? O_HI[OW-1:0] : (v < O_LO) ? O_LO[OW-1:0] : v[OW-1:0];
            if ((v > O_HI) || (v < O_LO))
                o_sat_reg <= 1'b1;
            o_dz_reg <= p3_dz_reg;
            o_wz_reg <= p3_wz_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign depth      = o_dz_reg;
    assign w_was_zero = o_wz_reg;
    assign saturated  = o_sat_reg;

endmodule

[hdl/vpp_checker.sv]
// Port-level checks for the vertex projection block, bound to the top level.
// Depends on vpp_pkg and vertex_perspective_projection.

module vpp_port_checker
#(
    parameter int QueueDepth = vpp_pkg::QUEUE_DEPTH
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Two front stages, the queue, stage zero, the divider, three post stages, output.
    localparam int Capacity = 2 + QueueDepth + 1 + vpp_pkg::NUM_W + 3 + 1;

    logic       in_acc;
    logic       out_acc;
    logic [7:0] pending_reg;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_acc && !out_acc)
            pending_reg <= pending_reg + 1'b1;
        else if (out_acc && !in_acc)
            pending_reg <= pending_reg - 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("output transaction without a pending vertex");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(Capacity))
        else $error("more vertices in flight than the pipeline holds");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 8'd0 |-> s_tready)
        else $error("input stalled while the block is empty");

endmodule

bind vertex_perspective_projection vpp_port_checker #(.QueueDepth(QueueDepth)) u_vpp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
